// ----- rtl/psl_pkg.sv -----
// Package for the patience sort subsequence engine: field widths, limits,
// defaults and the controller state type. No dependencies.
package psl_pkg;

   localparam int ELEM_W  = 16;
   localparam int TOTAL_W = 26;
   localparam int LEN_W   = 7;

   localparam longint TOTAL_MAX = 64'sd33554431;
   localparam longint TOTAL_MIN = -64'sd33554432;

   localparam int DEF_MAX_ITEMS   = 1024;
   localparam int DEF_MAX_PILES   = 64;
   localparam int DEF_VALUE_WIDTH = 16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE,
      ST_WALK_TOP,
      ST_WALK,
      ST_EMIT_RD,
      ST_EMIT_LD,
      ST_EMIT_OUT
   } psl_state_type;

endpackage

// ----- rtl/psl_ram.sv -----
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module psl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ----- rtl/patience_sort_lis_engine_unit.sv -----
// Patience sort engine: builds piles from signed words and emits the longest
// non-decreasing subsequence when a zero word arrives.
// A nonzero word is placed by scanning the pile tops in order; the scan reads
// one pile top and one node per cycle through the RAM ports.
// A zero word walks the back links, then emits one result word per element.
// Synchronous reset clears the counters and control; the RAMs are not cleared.
module patience_sort_lis_engine_unit #(
   parameter int MAX_ITEMS   = psl_pkg::DEF_MAX_ITEMS,
   parameter int MAX_PILES   = psl_pkg::DEF_MAX_PILES,
   parameter int VALUE_WIDTH = psl_pkg::DEF_VALUE_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [psl_pkg::ELEM_W-1:0]   req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [psl_pkg::ELEM_W-1:0]   rsp_element,
   output logic signed [psl_pkg::TOTAL_W-1:0]  rsp_total,
   output logic [psl_pkg::LEN_W-1:0]           rsp_length,
   output logic                                rsp_overflow,
   output logic                                rsp_has_element,
   output logic                                rsp_last
);
   import psl_pkg::*;

   localparam int IDX_W  = $clog2(MAX_ITEMS);
   localparam int LINK_W = $clog2(MAX_ITEMS + 1);
   localparam int PIDX_W = $clog2(MAX_PILES);
   localparam int PC_W   = $clog2(MAX_PILES + 1);
   localparam int SUM_W  = VALUE_WIDTH + PC_W;
   localparam int NODE_W = VALUE_WIDTH + LINK_W;

   psl_state_type state_ff, state_in;

   logic signed [VALUE_WIDTH-1:0] v_ff, v_in;
   logic [PC_W-1:0]   pc_ff, pc_in;
   logic [LINK_W-1:0] nc_ff, nc_in;
   logic              drop_ff, drop_in;
   logic [PC_W-1:0]   issue_ff, issue_in;
   logic              s1_vld_ff, s1_vld_in, s2_vld_ff, s2_vld_in;
   logic [PC_W-1:0]   s1_idx_ff, s1_idx_in, s2_idx_ff, s2_idx_in;
   logic [IDX_W-1:0]  s2_top_ff, s2_top_in, last_top_ff, last_top_in;
   logic [PC_W-1:0]   slot_ff, slot_in;
   logic [LINK_W-1:0] link_ff, link_in;
   logic [PC_W-1:0]   k_ff, k_in;
   logic              lnk_ok_ff, lnk_ok_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;

   logic signed [ELEM_W-1:0]  out_elem_ff, out_elem_in;
   logic signed [TOTAL_W-1:0] out_total_ff, out_total_in;
   logic [LEN_W-1:0]          out_len_ff, out_len_in;
   logic out_ovf_ff, out_ovf_in, out_has_ff, out_has_in, out_last_ff, out_last_in;

   // RAM ports
   logic              node_we, pile_we, emit_we;
   logic [IDX_W-1:0]  node_waddr, node_raddr;
   logic [NODE_W-1:0] node_wdata, node_rdata;
   logic [PIDX_W-1:0] pile_waddr, pile_raddr, emit_waddr, emit_raddr;
   logic [IDX_W-1:0]  pile_wdata, pile_rdata;
   logic [VALUE_WIDTH-1:0] emit_wdata, emit_rdata;

   logic [31:0]       req_zx;
   logic [VALUE_WIDTH-1:0] req_v;
   logic signed [VALUE_WIDTH-1:0] node_val, walk_e;
   logic [LINK_W-1:0] node_link, back_m1;
   logic [PC_W-1:0]   pc_m1, k_m1;
   logic signed [63:0] sum_wide, elem_wide;
   logic signed [TOTAL_W-1:0] total_sat;
   logic              fin;

   psl_ram #(.WIDTH(NODE_W), .DEPTH(MAX_ITEMS)) u_node_ram (
      .clock(clock), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
      .raddr(node_raddr), .rdata(node_rdata)
   );

   psl_ram #(.WIDTH(IDX_W), .DEPTH(MAX_PILES)) u_pile_ram (
      .clock(clock), .we(pile_we), .waddr(pile_waddr), .wdata(pile_wdata),
      .raddr(pile_raddr), .rdata(pile_rdata)
   );

   psl_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_PILES)) u_emit_ram (
      .clock(clock), .we(emit_we), .waddr(emit_waddr), .wdata(emit_wdata),
      .raddr(emit_raddr), .rdata(emit_rdata)
   );

   assign req_zx    = 32'($unsigned(req_value));
   assign req_v     = req_zx[VALUE_WIDTH-1:0];
   assign node_val  = $signed(node_rdata[NODE_W-1:LINK_W]);
   assign node_link = node_rdata[LINK_W-1:0];
   assign back_m1   = node_link - LINK_W'(1);
   assign pc_m1     = pc_ff - PC_W'(1);
   assign k_m1      = k_ff - PC_W'(1);
   assign walk_e    = lnk_ok_ff ? node_val : '0;
   assign sum_wide  = 64'(sum_ff);
   assign elem_wide = 64'($signed(emit_rdata));
   assign fin       = (k_ff == pc_m1);

   always_comb begin
      if (sum_wide > TOTAL_MAX) begin
         total_sat = TOTAL_W'(TOTAL_MAX);
      end else if (sum_wide < TOTAL_MIN) begin
         total_sat = TOTAL_W'(TOTAL_MIN);
      end else begin
         total_sat = sum_wide[TOTAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         pc_ff     <= '0;
         nc_ff     <= '0;
         drop_ff   <= 1'b0;
         issue_ff  <= '0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pc_ff     <= pc_in;
         nc_ff     <= nc_in;
         drop_ff   <= drop_in;
         issue_ff  <= issue_in;
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff         <= v_in;
      s1_idx_ff    <= s1_idx_in;
      s2_idx_ff    <= s2_idx_in;
      s2_top_ff    <= s2_top_in;
      last_top_ff  <= last_top_in;
      slot_ff      <= slot_in;
      link_ff      <= link_in;
      k_ff         <= k_in;
      lnk_ok_ff    <= lnk_ok_in;
      sum_ff       <= sum_in;
      out_elem_ff  <= out_elem_in;
      out_total_ff <= out_total_in;
      out_len_ff   <= out_len_in;
      out_ovf_ff   <= out_ovf_in;
      out_has_ff   <= out_has_in;
      out_last_ff  <= out_last_in;
   end

   always_comb begin
      state_in     = state_ff;
      v_in         = v_ff;
      pc_in        = pc_ff;
      nc_in        = nc_ff;
      drop_in      = drop_ff;
      issue_in     = '0;
      s1_vld_in    = 1'b0;
      s1_idx_in    = s1_idx_ff;
      s2_vld_in    = 1'b0;
      s2_idx_in    = s1_idx_ff;
      s2_top_in    = pile_rdata;
      last_top_in  = last_top_ff;
      slot_in      = slot_ff;
      link_in      = link_ff;
      k_in         = k_ff;
      lnk_ok_in    = lnk_ok_ff;
      sum_in       = sum_ff;
      out_elem_in  = out_elem_ff;
      out_total_in = out_total_ff;
      out_len_in   = out_len_ff;
      out_ovf_in   = out_ovf_ff;
      out_has_in   = out_has_ff;
      out_last_in  = out_last_ff;
      node_we      = 1'b0;
      node_waddr   = nc_ff[IDX_W-1:0];
      node_wdata   = {v_ff, link_ff};
      node_raddr   = pile_rdata;
      pile_we      = 1'b0;
      pile_waddr   = slot_ff[PIDX_W-1:0];
      pile_wdata   = nc_ff[IDX_W-1:0];
      pile_raddr   = pc_m1[PIDX_W-1:0];
      emit_we      = 1'b0;
      emit_waddr   = k_m1[PIDX_W-1:0];
      emit_wdata   = walk_e;
      emit_raddr   = k_ff[PIDX_W-1:0];
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               v_in = $signed(req_v);
               if (req_v != '0) begin
                  if (nc_ff >= LINK_W'(MAX_ITEMS)) begin
                     drop_in = 1'b1;
                  end else if (pc_ff == '0) begin
                     slot_in  = '0;
                     link_in  = '0;
                     state_in = ST_WRITE;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end else if (pc_ff == '0) begin
                  out_elem_in  = '0;
                  out_total_in = '0;
                  out_len_in   = '0;
                  out_ovf_in   = drop_ff;
                  out_has_in   = 1'b0;
                  out_last_in  = 1'b1;
                  state_in     = ST_EMIT_OUT;
               end else begin
                  // The pile RAM is already reading the last pile's top.
                  k_in     = pc_ff;
                  sum_in   = '0;
                  state_in = ST_WALK_TOP;
               end
            end
         end
         ST_SCAN: begin
            // Three-deep pipeline: pile top read, node read, compare.
            pile_raddr = issue_ff[PIDX_W-1:0];
            if (issue_ff < pc_ff) begin
               s1_vld_in = 1'b1;
               issue_in  = issue_ff + PC_W'(1);
            end else begin
               issue_in  = issue_ff;
            end
            s1_idx_in = issue_ff;
            s2_vld_in = s1_vld_ff;
            if (s2_vld_ff) begin
               if (node_val > v_ff) begin
                  slot_in   = s2_idx_ff;
                  link_in   = (s2_idx_ff == '0) ? '0 : LINK_W'(last_top_ff) + LINK_W'(1);
                  state_in  = ST_WRITE;
                  issue_in  = '0;
                  s1_vld_in = 1'b0;
                  s2_vld_in = 1'b0;
               end else begin
                  last_top_in = s2_top_ff;
                  if (s2_idx_ff == pc_m1) begin
                     slot_in   = pc_ff;
                     link_in   = LINK_W'(s2_top_ff) + LINK_W'(1);
                     state_in  = ST_WRITE;
                     issue_in  = '0;
                     s1_vld_in = 1'b0;
                     s2_vld_in = 1'b0;
                  end
               end
            end
         end
         ST_WRITE: begin
            if (slot_ff == pc_ff && pc_ff == PC_W'(MAX_PILES)) begin
               drop_in = 1'b1;
            end else begin
               node_we = 1'b1;
               pile_we = 1'b1;
               nc_in   = nc_ff + LINK_W'(1);
               if (slot_ff == pc_ff) begin
                  pc_in = pc_ff + PC_W'(1);
               end
            end
            state_in = ST_IDLE;
         end
         ST_WALK_TOP: begin
            node_raddr = pile_rdata;
            lnk_ok_in  = 1'b1;
            state_in   = ST_WALK;
         end
         ST_WALK: begin
            // Fill the buffer from the back, one node per cycle.
            emit_we    = 1'b1;
            sum_in     = sum_ff + SUM_W'(walk_e);
            lnk_ok_in  = lnk_ok_ff && (node_link != '0);
            node_raddr = back_m1[IDX_W-1:0];
            k_in       = k_m1;
            if (k_ff == PC_W'(1)) begin
               k_in     = '0;
               state_in = ST_EMIT_RD;
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            out_elem_in  = elem_wide[ELEM_W-1:0];
            out_total_in = fin ? total_sat : '0;
            out_len_in   = fin ? LEN_W'(pc_ff) : '0;
            out_ovf_in   = drop_ff;
            out_has_in   = 1'b1;
            out_last_in  = fin;
            state_in     = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (out_last_ff) begin
                  pc_in    = '0;
                  nc_in    = '0;
                  drop_in  = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + PC_W'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_element     = out_elem_ff;
   assign rsp_total       = out_total_ff;
   assign rsp_length      = out_len_ff;
   assign rsp_overflow    = out_ovf_ff;
   assign rsp_has_element = out_has_ff;
   assign rsp_last        = out_last_ff;

endmodule

// ----- rtl/psl_checker.sv -----
// Port-level checks for the patience sort engine, bound to the top level.
// Depends on psl_pkg and patience_sort_lis_engine_unit.
module psl_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [psl_pkg::ELEM_W-1:0]  rsp_element,
   input logic signed [psl_pkg::TOTAL_W-1:0] rsp_total,
   input logic [psl_pkg::LEN_W-1:0]          rsp_length,
   input logic                               rsp_has_element,
   input logic                               rsp_last
);
   import psl_pkg::*;

   // An empty set is the only word without an element, and it ends the run.
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_element |-> rsp_last && rsp_length == '0)
      else $error("element-less word is not a final empty result");

   a_mid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_length == '0 && rsp_total == '0)
      else $error("total or length set on a word before the last");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken while a result is pending");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown straight after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_element) && $stable(rsp_last))
      else $error("stalled result changed");

endmodule

bind patience_sort_lis_engine_unit psl_checker u_psl_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_element(rsp_element),
   .rsp_total(rsp_total), .rsp_length(rsp_length),
   .rsp_has_element(rsp_has_element), .rsp_last(rsp_last)
);

// ----- tb/tb_top.sv -----
// Self-checking bench for the patience sort subsequence engine: a directed table
// and then random sets, each checked against a built-in pile model.
// Depends on psl_pkg and patience_sort_lis_engine_unit.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import psl_pkg::*;

   localparam int NODES = DEF_MAX_ITEMS;
   localparam int PILES = DEF_MAX_PILES;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct packed {
      logic signed [ELEM_W-1:0]  element;
      logic signed [TOTAL_W-1:0] total;
      logic [LEN_W-1:0]          length;
      logic                      overflow;
      logic                      has_element;
      logic                      last;
   } lis_word_type;

   typedef struct {
      logic signed [ELEM_W-1:0] value;
      bit                       typed;
      lis_word_type             want;
   } table_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [ELEM_W-1:0] req_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [ELEM_W-1:0]  rsp_element;
   logic signed [TOTAL_W-1:0] rsp_total;
   logic [LEN_W-1:0]          rsp_length;
   logic rsp_overflow, rsp_has_element, rsp_last;

   patience_sort_lis_engine_unit dut (.*);

   always #1 clock = ~clock;

   // Model state of the piles.
   logic signed [ELEM_W-1:0] node_val [NODES];
   int unsigned node_link [NODES];
   int unsigned top_of [PILES];
   int unsigned piles, nodes;
   bit dropped;

   lis_word_type lis_q[$];
   table_row_type rows [$];
   int errors = 0;
   int idle_pct = 0;
   int stall_pct = 0;
   longint cycles = 0;

   function automatic void add_word(lis_word_type w);
      lis_q.insert(lis_q.size(), w);
   endfunction

   function automatic void add_row(logic signed [ELEM_W-1:0] v, bit typed = 0,
                                   lis_word_type want = '0);
      rows.insert(rows.size(), '{v, typed, want});
   endfunction

   function automatic void place_or_emit(logic signed [ELEM_W-1:0] v);
      int unsigned slot, link;
      longint sum;
      logic signed [ELEM_W-1:0] chain [PILES];
      lis_word_type w;
      if (v != 0) begin
         if (nodes >= NODES) begin
            dropped = 1'b1;
            return;
         end
         slot = piles;
         for (int i = 0; i < piles; i++) begin
            if (node_val[top_of[i]] > v) begin
               slot = i;
               break;
            end
         end
         if (slot >= piles && piles >= PILES) begin
            dropped = 1'b1;
            return;
         end
         node_val[nodes] = v;
         node_link[nodes] = (slot > 0) ? top_of[slot-1] + 1 : 0;
         top_of[slot] = nodes;
         if (slot >= piles) piles++;
         nodes++;
         return;
      end
      if (piles == 0) begin
         w = '0;
         w.overflow = dropped;
         w.last = 1'b1;
         add_word(w);
      end else begin
         sum = 0;
         link = top_of[piles-1] + 1;
         for (int k = piles; k > 0; k--) begin
            chain[k-1] = node_val[link-1];
            sum += chain[k-1];
            link = node_link[link-1];
         end
         if (sum > TOTAL_MAX) sum = TOTAL_MAX;
         if (sum < TOTAL_MIN) sum = TOTAL_MIN;
         for (int k = 0; k < piles; k++) begin
            w = '0;
            w.element = chain[k];
            w.overflow = dropped;
            w.has_element = 1'b1;
            if (k + 1 == piles) begin
               w.total = sum[TOTAL_W-1:0];
               w.length = piles[LEN_W-1:0];
               w.last = 1'b1;
            end
            add_word(w);
         end
      end
      piles = 0;
      nodes = 0;
      dropped = 1'b0;
   endfunction

   // Present one word; valid stays high across back-to-back words.
   task automatic send_word(logic signed [ELEM_W-1:0] v, bit typed = 0,
                            lis_word_type want = '0);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (!req_ready);
      place_or_emit(v);
      if (typed) begin
         lis_q[lis_q.size() - 1] = want;
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (lis_q.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   function automatic logic signed [ELEM_W-1:0] rand_nonzero(bit narrow);
      logic signed [ELEM_W-1:0] v;
      do begin
         if (narrow) v = ELEM_W'(int'($urandom_range(60)) - 30);
         else v = ELEM_W'($urandom);
      end while (v == 0);
      return v;
   endfunction

   task automatic random_set();
      int n, kind;
      kind = $urandom_range(9);
      n = (kind == 1) ? 0 : $urandom_range(1, 4);
      for (int i = 0; i < n; i++) send_word(rand_nonzero(kind > 5));
      send_word('0);
   endtask

   always @(negedge clock) rsp_ready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         lis_word_type got, want;
         got = {rsp_element, rsp_total, rsp_length, rsp_overflow,
                rsp_has_element, rsp_last};
         if (lis_q.size() == 0) begin
            $display("%0t unexpected word: expected none actual %p", $realtime, got);
            errors++;
         end else begin
            want = lis_q.pop_front();
            if (got !== want) begin
               $display("%0t mismatch: expected %p actual %p", $realtime, want, got);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      lis_word_type one;
      piles = 0;
      nodes = 0;
      dropped = 1'b0;
      one = '0;
      one.last = 1'b1;
      add_row(16'sd0, 1, one);
      one = '{16'sd32767, 26'sd32767, 7'd1, 1'b0, 1'b1, 1'b1};
      add_row(16'sd32767);
      add_row(16'sd0, 1, one);
      add_row(-16'sd32768);
      add_row(16'sd32767);
      add_row(-16'sd1);
      add_row(16'sd1);
      add_row(16'sd0);
      for (int i = 0; i < 3; i++) add_row(16'sd5);
      add_row(16'sd0);
      add_row(16'sd3);
      add_row(16'sd2);
      add_row(16'sd1);
      one = '{16'sd1, 26'sd1, 7'd1, 1'b0, 1'b1, 1'b1};
      add_row(16'sd0, 1, one);
      add_row(-16'sd32768);
      add_row(16'sd0);
      add_row(16'sd21845);
      add_row(-16'sd21846);
      add_row(16'sd0);
      // A rising run one longer than the pile limit, so the last word is dropped.
      for (int i = 1; i <= PILES + 1; i++) add_row(ELEM_W'(i));
      add_row(16'sd0);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) send_word(rows[i].value, rows[i].typed, rows[i].want);

      for (int phase = 0; phase < 4; phase++) begin
         idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 36 : 50) : 0;
         stall_pct = (phase == 2) ? 50 : ((phase == 3) ? 36 : 0);
         random_set();
         // Hold the sender until every pending word has come back.
         drain();
         random_set();
      end
      drain();

      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
